/* rtl/rxrb_pkg.sv */
// rxrb_pkg: types and constants shared by the receive ring buffer modules
`default_nettype none

package rxrb_pkg;

  localparam int BYTE_W = 8;
  localparam int FILL_W = 7;
  localparam int CNT_W  = 32;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [BYTE_W-1:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              was_empty;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  overflow_total;
  } out_t;

  // status carried beside the ram read while the read data is in flight
  typedef struct packed {
    logic              pop_ok;
    logic              was_empty;
    logic [FILL_W-1:0] fill_level;
    logic [CNT_W-1:0]  overflow_total;
  } stage_t;

endpackage

`default_nettype wire

/* rtl/rxrb_ram.sv */
// rxrb_ram: generic single write port, single read port ram with registered read
`default_nettype none

module rxrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/rx_ring_buffer_drop_oldest.sv */
// rx_ring_buffer_drop_oldest: receive byte ring with drop-oldest overflow and counter
// a result passes through the ram read stage, then the output register
// throughput: one transaction per cycle while in_stall is low; the single ram port pair sets this
// reset clears the pointers, the overflow counter and all valid flags at once;
//   the byte store is not cleared
`default_nettype none

module rx_ring_buffer_drop_oldest import rxrb_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire in_t  in_data,
  output      logic out_valid,
  input  wire logic out_stall,
  output      out_t out_data
);

  localparam int PW = $clog2(DEPTH);

  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  drop_cnt_r, drop_cnt_nxt;
  logic [PW-1:0]     wr_ptr_inc, rd_ptr_inc, fill_diff;
  logic              empty, full;
  logic              in_acc, s1_adv, out_ready;
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic              s1_valid_r;
  stage_t            s1_r, s1_nxt;
  logic              out_valid_r;
  out_t              out_data_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_acc    = in_valid && !in_stall;

  assign wr_ptr_inc = wr_ptr_r + PW'(1);
  assign rd_ptr_inc = rd_ptr_r + PW'(1);
  assign empty      = (wr_ptr_r == rd_ptr_r);
  assign full       = (wr_ptr_inc == rd_ptr_r);

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    drop_cnt_nxt = drop_cnt_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    s1_nxt       = '0;
    if (in_acc) begin
      unique case (in_data.mode)
        MODE_PUSH: begin
          // full ring: drop the oldest byte to make room
          if (full) begin
            rd_ptr_nxt   = rd_ptr_inc;
            drop_cnt_nxt = drop_cnt_r + CNT_W'(1);
          end
          ram_we     = 1'b1;
          wr_ptr_nxt = wr_ptr_inc;
        end
        MODE_POP: begin
          if (empty) begin
            s1_nxt.was_empty = 1'b1;
          end else begin
            ram_re        = 1'b1;
            s1_nxt.pop_ok = 1'b1;
            rd_ptr_nxt    = rd_ptr_inc;
          end
        end
        MODE_FLUSH: begin
          rd_ptr_nxt = wr_ptr_r;
        end
        MODE_CLEAR: begin
          drop_cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    fill_diff             = wr_ptr_nxt - rd_ptr_nxt;
    s1_nxt.fill_level     = FILL_W'(fill_diff);
    s1_nxt.overflow_total = drop_cnt_nxt;
  end

  rxrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_data.rx_byte),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      drop_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      drop_cnt_r <= drop_cnt_nxt;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_data_r.read_byte      <= s1_r.pop_ok ? ram_rdata : '0;
      out_data_r.was_empty      <= s1_r.was_empty;
      out_data_r.fill_level     <= s1_r.fill_level;
      out_data_r.overflow_total <= s1_r.overflow_total;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an empty pop leaves nothing in the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_r.was_empty |-> s1_r.fill_level == '0)
    else $error("empty pop reported nonzero fill level");

  // the counter moves up by one on every push into a full ring
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode == MODE_PUSH && full |=>
      drop_cnt_r == $past(drop_cnt_r) + CNT_W'(1))
    else $error("overflow counter missed a dropped byte");

  // after a push the ring is never empty
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode == MODE_PUSH |=> wr_ptr_r != rd_ptr_r)
    else $error("push left the ring empty");

  // input is held back only when both stages are occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire

/* dv/rx_ring_buffer_drop_oldest_tb.sv */
// rx_ring_buffer_drop_oldest_tb: self-checking testbench for the drop-oldest receive byte ring
`default_nettype none

module rx_ring_buffer_drop_oldest_tb import rxrb_pkg::*; ();

  localparam int RING_DEPTH     = 128;
  localparam int PTR_W          = $clog2(RING_DEPTH);
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 100;

  // tracks ring contents, pointers and drop count; holds expected results in order
  class byte_ring_scoreboard;
    logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [CNT_W-1:0]  drops;
    out_t              expected_q [$];
    int                errors;

    function new();
      head   = '0;
      tail   = '0;
      drops  = '0;
      errors = 0;
    endfunction

    function void note_input(in_t it);
      out_t res;
      res = '0;
      case (it.mode)
        MODE_PUSH: begin
          // full ring: the oldest byte goes first
          if (PTR_W'(head + 1'b1) == tail) begin
            tail  = tail + 1'b1;
            drops = drops + 1'b1;
          end
          ring_bytes[head] = it.rx_byte;
          head = head + 1'b1;
        end
        MODE_POP: begin
          if (head == tail) begin
            res.was_empty = 1'b1;
          end else begin
            res.read_byte = ring_bytes[tail];
            tail = tail + 1'b1;
          end
        end
        MODE_FLUSH: tail = head;
        default: drops = '0;
      endcase
      res.fill_level     = FILL_W'(PTR_W'(head - tail));
      res.overflow_total = drops;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] exp_v, logic [CNT_W-1:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("read_byte", CNT_W'(exp_r.read_byte), CNT_W'(got.read_byte));
      compare_field("was_empty", CNT_W'(exp_r.was_empty), CNT_W'(got.was_empty));
      compare_field("fill_level", CNT_W'(exp_r.fill_level), CNT_W'(got.fill_level));
      compare_field("overflow_total", exp_r.overflow_total, got.overflow_total);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  byte_ring_scoreboard ring_sb;
  int snd_idle_pct;
  int rcv_idle_pct;
  int items_sent;
  int quiet_cycles;
  bit hold_req;

  always #10 clk = ~clk;

  rx_ring_buffer_drop_oldest #(.DEPTH(RING_DEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ring_sb.note_input(in_data);
      if (out_valid && !out_stall) ring_sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side stalls; a hold request freezes it long enough to back up the input
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  function automatic in_t make_item(mode_t m, logic [BYTE_W-1:0] b);
    in_t it;
    it.mode    = m;
    it.rx_byte = b;
    return it;
  endfunction

  task automatic send_item(in_t it);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_byte(mode_t m);
    send_item(make_item(m, BYTE_W'($urandom_range(0, 255))));
  endtask

  // bursts of pushes and pops keep the fill level moving
  task automatic run_random(int n_items);
    int stop_at;
    int kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: repeat ($urandom_range(1, 40)) send_random_byte(MODE_PUSH);
        2, 3: repeat ($urandom_range(1, 40)) send_random_byte(MODE_POP);
        4: send_random_byte(MODE_FLUSH);
        5: send_random_byte(MODE_CLEAR);
        default: send_random_byte(mode_t'($urandom_range(MODE_PUSH, MODE_CLEAR)));
      endcase
    end
  endtask

  initial begin
    ring_sb      = new();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    items_sent   = 0;
    quiet_cycles = 0;
    hold_req     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pops, byte extremes, flush and counter clear
    send_item(make_item(MODE_POP, 8'h00));
    send_item(make_item(MODE_FLUSH, 8'hFF));
    send_item(make_item(MODE_CLEAR, 8'h00));
    send_item(make_item(MODE_PUSH, 8'h00));
    send_item(make_item(MODE_PUSH, 8'hFF));
    send_item(make_item(MODE_PUSH, 8'hA5));
    send_item(make_item(MODE_PUSH, 8'h5A));
    send_item(make_item(MODE_POP, 8'hFF));
    send_item(make_item(MODE_POP, 8'h00));
    send_item(make_item(MODE_FLUSH, 8'h00));
    send_item(make_item(MODE_POP, 8'h55));
    send_item(make_item(MODE_PUSH, 8'h01));
    send_item(make_item(MODE_PUSH, 8'h80));
    send_item(make_item(MODE_POP, 8'h00));
    send_item(make_item(MODE_POP, 8'h00));
    send_item(make_item(MODE_POP, 8'h00));
    send_item(make_item(MODE_CLEAR, 8'hFF));

    // phase one: overrun the ring under a long result-side hold, clear the counter, then pop a quarter of the ring
    snd_idle_pct = 21;
    rcv_idle_pct = 66;
    hold_req     = 1'b1;
    repeat ($urandom_range(RING_DEPTH + 2, RING_DEPTH + 8)) send_random_byte(MODE_PUSH);
    send_random_byte(MODE_PUSH);
    send_random_byte(MODE_CLEAR);
    repeat (RING_DEPTH / 4) send_random_byte(MODE_POP);
    run_random(PHASE_ITEMS / 3);

    snd_idle_pct = 66;
    rcv_idle_pct = 21;
    run_random(PHASE_ITEMS);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (ring_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ring_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/rxrb_pkg.sv
rtl/rxrb_ram.sv
rtl/rx_ring_buffer_drop_oldest.sv
dv/rx_ring_buffer_drop_oldest_tb.sv
